FILE: hdl/tss_pkg.sv
// Task state scheduler package: slot states, request modes, status codes
// and FSM states. No dependencies.
package tss_pkg;

  localparam int ModeW = 3;
  localparam int WaitIdW = 16;
  localparam int PidW = 32;

  typedef enum logic [2:0] {
    ST_UNUSED   = 3'd0,
    ST_READY    = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_SLEEPING = 3'd3,
    ST_KILLED   = 3'd4
  } slot_state_t;

  typedef enum logic [2:0] {
    MODE_CREATE = 3'd0,
    MODE_START  = 3'd1,
    MODE_YIELD  = 3'd2,
    MODE_SLEEP  = 3'd3,
    MODE_WAKEUP = 3'd4,
    MODE_EXIT   = 3'd5,
    MODE_REAP   = 3'd6,
    MODE_NONE   = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_NO_SLOT  = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_NO_TASK  = 3'd3,
    STAT_STARTED  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_WAKE,
    FSM_FINISH,
    FSM_OUT
  } fsm_t;

endpackage

FILE: hdl/tss_if.sv
// Valid/ready channel interfaces for the task state scheduler.
// No dependencies.
interface tss_req_if;
  logic valid;
  logic ready;
  logic [2:0] mode;
  logic [15:0] wait_id;
  modport source (output valid, mode, wait_id, input ready);
  modport sink (input valid, mode, wait_id, output ready);
endinterface

interface tss_rsp_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [4:0] running_slot;
  logic [31:0] running_pid;
  logic switched;
  logic [3:0] created_slot;
  logic [31:0] created_pid;
  logic [4:0] woken_count;
  logic reaped_valid;
  logic [3:0] reaped_slot;
  modport source (output valid, status, running_slot, running_pid, switched,
                  created_slot, created_pid, woken_count, reaped_valid, reaped_slot,
                  input ready);
  modport sink (input valid, status, running_slot, running_pid, switched,
                created_slot, created_pid, woken_count, reaped_valid, reaped_slot,
                output ready);
endinterface

FILE: hdl/tss_cell.sv
// One wait-list cell: a slot number plus its wait id; shifts toward the head.
// Depends on tss_pkg.
module tss_cell #(
  parameter int IdxW = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               shift,
  input  logic               load,
  input  logic               in_vld,
  input  logic [IdxW-1:0]    in_slot,
  input  logic [15:0]        in_event,
  output logic               vld,
  output logic [IdxW-1:0]    slot,
  output logic [15:0]        event_id
);
  import tss_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (shift || load) begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (shift || load) begin
      slot <= in_slot;
      event_id <= in_event;
    end
  end
endmodule

FILE: hdl/task_state_scheduler.sv
// Task state scheduler top level: slot table, ready and kill rings,
// wait list built as a row of tss_cell. Depends on tss_pkg, tss_if, tss_cell.
//
// Usage: requests arrive on req (mode, wait_id); one response per request
// leaves on rsp. cfg_we/cfg_data write init_wait_id: the user is to write
// it at any idle clock edge only, which the block itself does not enforce.
// One request at a time. Create scans one slot per cycle from the bottom
// up to the first unused one or the last slot. Wakeup, and exit with a
// running task, cycle the wait list through its cells once. The wait list
// walk sets the worst-case time from one request to the next.
// The response is valid in FSM_OUT, the state before FSM_IDLE, in which
// the next request can be accepted.
// Reset (rst, synchronous) empties all queues, marks every slot unused,
// sets no running task, pid counter to 1 and init_wait_id to 1.
// A stalled rsp holds the response; the next request is not taken until
// it leaves.
module task_state_scheduler #(
  parameter int SLOTS = 16
) (
  input  logic clk,
  input  logic rst,
  tss_req_if.sink   req,
  tss_rsp_if.source rsp,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);
  import tss_pkg::*;

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CntW = $clog2(SLOTS + 1);
  localparam logic [CntW-1:0] NoTask = CntW'(SLOTS);
  localparam logic [CntW-1:0] LastIdx = CntW'(SLOTS - 1);

  logic [15:0] init_wait_id;
  slot_state_t slot_st [SLOTS];
  logic [31:0] slot_pid [SLOTS];
  logic [IdxW-1:0] ready_fifo [SLOTS];
  logic [IdxW-1:0] kill_fifo [SLOTS];
  logic [IdxW-1:0] ready_head, kill_head;
  logic [CntW-1:0] ready_count, kill_count, wait_count;
  logic [CntW-1:0] current_task, prev_task;
  logic [31:0] next_pid;

  fsm_t state, state_next;
  mode_t mode;
  logic [15:0] wid;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] woken, wake_len;

  status_t r_status;
  logic [3:0] r_cslot;
  logic [31:0] r_cpid;
  logic r_rvalid;
  logic [3:0] r_rslot;

  // wait list cells; cell 0 is head, live entries packed from the head
  logic c_vld [SLOTS];
  logic [IdxW-1:0] c_slot [SLOTS];
  logic [15:0] c_ev [SLOTS];
  logic c_in_vld [SLOTS];
  logic [IdxW-1:0] c_in_slot [SLOTS];
  logic [15:0] c_in_ev [SLOTS];
  logic nb_vld [SLOTS];
  logic [IdxW-1:0] nb_slot [SLOTS];
  logic [15:0] nb_ev [SLOTS];
  logic c_shift [SLOTS];
  logic c_load [SLOTS];
  logic tail_vld;
  logic wake_step;
  logic do_park;
  logic [15:0] park_ev;

  logic head_match;
  logic [IdxW-1:0] cur_idx, cnt_idx, rtail, ktail;

  // wake step: head leaves, kept heads re-enter behind the last live entry
  // park: the sleeping task is loaded into the first free cell
  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      if (g == SLOTS - 1) begin : g_last
        assign nb_vld[g] = 1'b0;
        assign nb_slot[g] = '0;
        assign nb_ev[g] = '0;
      end else begin : g_mid
        assign nb_vld[g] = c_vld[g+1];
        assign nb_slot[g] = c_slot[g+1];
        assign nb_ev[g] = c_ev[g+1];
      end
      assign c_shift[g] = wake_step && (CntW'(g) < wait_count);
      assign c_load[g] = do_park && (CntW'(g) == wait_count);
      assign c_in_vld[g] = do_park ? 1'b1
                         : (CntW'(g + 1) == wait_count) ? tail_vld : nb_vld[g];
      assign c_in_slot[g] = do_park ? cur_idx
                          : (CntW'(g + 1) == wait_count) ? c_slot[0] : nb_slot[g];
      assign c_in_ev[g] = do_park ? park_ev
                        : (CntW'(g + 1) == wait_count) ? c_ev[0] : nb_ev[g];
      tss_cell #(.IdxW(IdxW)) u_cell (
        .clk(clk), .rst(rst), .shift(c_shift[g]), .load(c_load[g]),
        .in_vld(c_in_vld[g]), .in_slot(c_in_slot[g]), .in_event(c_in_ev[g]),
        .vld(c_vld[g]), .slot(c_slot[g]), .event_id(c_ev[g])
      );
    end
  endgenerate

  assign cur_idx = current_task[IdxW-1:0];
  assign cnt_idx = cnt[IdxW-1:0];
  assign head_match = c_vld[0] && (c_ev[0] == wid);
  assign tail_vld = c_vld[0] && !head_match;
  assign wake_step = (state == FSM_WAKE) && (cnt != wake_len);
  assign do_park = (state == FSM_SCAN) && (current_task != NoTask) &&
                   (ready_count != '0) &&
                   ((mode == MODE_SLEEP) || (mode == MODE_REAP && kill_count == '0));
  assign park_ev = (mode == MODE_SLEEP) ? wid : init_wait_id;
  assign rtail = IdxW'((CntW+1)'(ready_head) + (CntW+1)'(ready_count) >= (CntW+1)'(SLOTS)
                 ? (CntW+1)'(ready_head) + (CntW+1)'(ready_count) - (CntW+1)'(SLOTS)
                 : (CntW+1)'(ready_head) + (CntW+1)'(ready_count));
  assign ktail = IdxW'((CntW+1)'(kill_head) + (CntW+1)'(kill_count) >= (CntW+1)'(SLOTS)
                 ? (CntW+1)'(kill_head) + (CntW+1)'(kill_count) - (CntW+1)'(SLOTS)
                 : (CntW+1)'(kill_head) + (CntW+1)'(kill_count));

  function automatic logic [IdxW-1:0] inc_idx(input logic [IdxW-1:0] i);
    inc_idx = ((CntW)'(i) == LastIdx) ? '0 : i + 1'b1;
  endfunction

  // exit with a running task, resolved after its wakeup pass
  logic exit_pending;

  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: if (req.valid) state_next = FSM_SCAN;
      FSM_SCAN: begin
        if (mode == MODE_CREATE) begin
          if (slot_st[cnt_idx] == ST_UNUSED || cnt == LastIdx) state_next = FSM_OUT;
        end else if (mode == MODE_WAKEUP ||
                     (mode == MODE_EXIT && current_task != NoTask)) begin
          state_next = FSM_WAKE;
        end else begin
          state_next = FSM_OUT;
        end
      end
      FSM_WAKE: if (cnt == wake_len) state_next = FSM_FINISH;
      FSM_FINISH: state_next = FSM_OUT;
      FSM_OUT: if (rsp.ready) state_next = FSM_IDLE;
      default: state_next = FSM_IDLE;
    endcase
  end

  assign req.ready = (state == FSM_IDLE);
  assign rsp.valid = (state == FSM_OUT);
  assign rsp.status = r_status;
  assign rsp.running_slot = 5'(current_task);
  assign rsp.running_pid = (current_task < NoTask) ? slot_pid[cur_idx] : '0;
  assign rsp.switched = (current_task != prev_task);
  assign rsp.created_slot = r_cslot;
  assign rsp.created_pid = r_cpid;
  assign rsp.woken_count = 5'(woken);
  assign rsp.reaped_valid = r_rvalid;
  assign rsp.reaped_slot = r_rslot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
      init_wait_id <= 16'd1;
      ready_head <= '0;
      ready_count <= '0;
      kill_head <= '0;
      kill_count <= '0;
      wait_count <= '0;
      current_task <= NoTask;
      prev_task <= NoTask;
      next_pid <= 32'd1;
      exit_pending <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_st[i] <= ST_UNUSED;
        slot_pid[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) init_wait_id <= cfg_data;
      unique case (state)
        FSM_IDLE: begin
          if (req.valid) begin
            mode <= mode_t'(req.mode);
            wid <= req.wait_id;
            cnt <= '0;
            woken <= '0;
            prev_task <= current_task;
            r_status <= STAT_OK;
            r_cslot <= '0;
            r_cpid <= '0;
            r_rvalid <= 1'b0;
            r_rslot <= '0;
            exit_pending <= 1'b0;
          end
        end
        FSM_SCAN: begin
          wake_len <= wait_count;
          unique case (mode)
            MODE_CREATE: begin
              if (slot_st[cnt_idx] == ST_UNUSED) begin
                slot_pid[cnt_idx] <= next_pid;
                next_pid <= next_pid + 32'd1;
                slot_st[cnt_idx] <= ST_READY;
                ready_fifo[rtail] <= cnt_idx;
                ready_count <= ready_count + 1'b1;
                r_cslot <= 4'(cnt);
                r_cpid <= next_pid;
              end else if (cnt == LastIdx) begin
                r_status <= STAT_NO_SLOT;
              end else begin
                cnt <= cnt + 1'b1;
              end
            end
            MODE_START: begin
              if (current_task < NoTask) r_status <= STAT_STARTED;
              else if (ready_count == '0) r_status <= STAT_EMPTY;
              else begin
                slot_st[ready_fifo[ready_head]] <= ST_RUNNING;
                current_task <= CntW'(ready_fifo[ready_head]);
                ready_head <= inc_idx(ready_head);
                ready_count <= ready_count - 1'b1;
              end
            end
            MODE_YIELD: begin
              if (current_task == NoTask) r_status <= STAT_NO_TASK;
              else if (ready_count != '0) begin
                ready_fifo[rtail] <= cur_idx;
                slot_st[cur_idx] <= ST_READY;
                slot_st[ready_fifo[ready_head]] <= ST_RUNNING;
                current_task <= CntW'(ready_fifo[ready_head]);
                ready_head <= inc_idx(ready_head);
              end
            end
            MODE_SLEEP, MODE_REAP: begin
              if (current_task == NoTask) r_status <= STAT_NO_TASK;
              else if (mode == MODE_REAP && kill_count != '0) begin
                slot_st[kill_fifo[kill_head]] <= ST_UNUSED;
                slot_pid[kill_fifo[kill_head]] <= '0;
                r_rvalid <= 1'b1;
                r_rslot <= 4'(kill_fifo[kill_head]);
                kill_head <= inc_idx(kill_head);
                kill_count <= kill_count - 1'b1;
              end else if (ready_count == '0) r_status <= STAT_EMPTY;
              else begin
                slot_st[cur_idx] <= ST_SLEEPING;
                slot_st[ready_fifo[ready_head]] <= ST_RUNNING;
                current_task <= CntW'(ready_fifo[ready_head]);
                ready_head <= inc_idx(ready_head);
                ready_count <= ready_count - 1'b1;
                wait_count <= wait_count + 1'b1;
              end
            end
            MODE_EXIT: begin
              wid <= init_wait_id;
              if (current_task == NoTask) r_status <= STAT_NO_TASK;
              else exit_pending <= 1'b1;
            end
            default: ;
          endcase
        end
        FSM_WAKE: begin
          if (cnt != wake_len) begin
            cnt <= cnt + 1'b1;
            if (head_match) begin
              ready_fifo[rtail] <= c_slot[0];
              slot_st[c_slot[0]] <= ST_READY;
              ready_count <= ready_count + 1'b1;
              wait_count <= wait_count - 1'b1;
              woken <= woken + 1'b1;
            end
          end
        end
        FSM_FINISH: begin
          if (exit_pending) begin
            if (ready_count == '0) begin
              r_status <= STAT_EMPTY;
            end else begin
              slot_st[cur_idx] <= ST_KILLED;
              kill_fifo[ktail] <= cur_idx;
              kill_count <= kill_count + 1'b1;
              slot_st[ready_fifo[ready_head]] <= ST_RUNNING;
              current_task <= CntW'(ready_fifo[ready_head]);
              ready_head <= inc_idx(ready_head);
              ready_count <= ready_count - 1'b1;
            end
          end
        end
        FSM_OUT: ;
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    ready_count <= NoTask) else $error("ready count overflow");
  a_out: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid) else $error("response dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready) else $error("request taken while busy");
`endif
endmodule

FILE: tb/tss_checker.sv
// Response checker for the task state scheduler: predicts each response from
// accepted requests and compares field by field. Depends on tss_pkg, tss_if.
module tss_checker
  import tss_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  tss_req_if          req,
  tss_rsp_if          rsp,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  running_slot;
    logic [31:0] running_pid;
    logic        switched;
    logic [3:0]  created_slot;
    logic [31:0] created_pid;
    logic [4:0]  woken_count;
    logic        reaped_valid;
    logic [3:0]  reaped_slot;
  } outcome_t;

  slot_state_t state_of [SLOTS];
  logic [31:0] pid_of   [SLOTS];
  logic [15:0] event_of [SLOTS];
  int          ready_q[$];
  int          sleepers[$];
  int          killed_q[$];
  int          running;
  logic [31:0] pid_next;
  logic [15:0] init_id;
  outcome_t    expected_q[$];

  function automatic void run_head();
    running = ready_q.pop_front();
    state_of[running] = ST_RUNNING;
  endfunction

  function automatic void enqueue_ready(int s);
    if (ready_q.size() < SLOTS) ready_q.push_back(s);
    state_of[s] = ST_READY;
  endfunction

  function automatic int waiters_on(logic [15:0] id);
    int n;
    n = 0;
    foreach (sleepers[i]) if (event_of[sleepers[i]] == id) n++;
    return n;
  endfunction

  function automatic int wake_all(logic [15:0] id);
    int keep[$];
    int n;
    n = 0;
    foreach (sleepers[i]) begin
      if (event_of[sleepers[i]] == id) begin
        enqueue_ready(sleepers[i]);
        n++;
      end else begin
        keep.push_back(sleepers[i]);
      end
    end
    sleepers = keep;
    return n;
  endfunction

  function automatic status_t put_to_sleep(logic [15:0] id);
    if (running >= SLOTS) return STAT_NO_TASK;
    if (ready_q.size() == 0) return STAT_EMPTY;
    state_of[running] = ST_SLEEPING;
    event_of[running] = id;
    if (sleepers.size() < SLOTS) sleepers.push_back(running);
    run_head();
    return STAT_OK;
  endfunction

  function automatic outcome_t schedule(mode_t m, logic [15:0] wid);
    outcome_t o;
    int prev, s;
    o = '0;
    prev = running;
    case (m)
      MODE_CREATE: begin
        s = SLOTS;
        for (int i = SLOTS - 1; i >= 0; i--) if (state_of[i] == ST_UNUSED) s = i;
        if (s >= SLOTS) o.status = STAT_NO_SLOT;
        else begin
          pid_of[s] = pid_next;
          event_of[s] = '0;
          pid_next = pid_next + 1;
          enqueue_ready(s);
          o.created_slot = s[3:0];
          o.created_pid = pid_of[s];
        end
      end
      MODE_START: begin
        if (running < SLOTS) o.status = STAT_STARTED;
        else if (ready_q.size() == 0) o.status = STAT_EMPTY;
        else run_head();
      end
      MODE_YIELD: begin
        if (running >= SLOTS) o.status = STAT_NO_TASK;
        else if (ready_q.size() != 0) begin
          enqueue_ready(running);
          run_head();
        end
      end
      MODE_SLEEP: o.status = put_to_sleep(wid);
      MODE_WAKEUP: o.woken_count = wake_all(wid);
      MODE_EXIT: begin
        if (running >= SLOTS) o.status = STAT_NO_TASK;
        else if (ready_q.size() == 0 && waiters_on(init_id) == 0) o.status = STAT_EMPTY;
        else begin
          state_of[running] = ST_KILLED;
          if (killed_q.size() < SLOTS) killed_q.push_back(running);
          o.woken_count = wake_all(init_id);
          run_head();
        end
      end
      MODE_REAP: begin
        if (running >= SLOTS) o.status = STAT_NO_TASK;
        else if (killed_q.size() > 0) begin
          s = killed_q.pop_front();
          state_of[s] = ST_UNUSED;
          pid_of[s] = '0;
          event_of[s] = '0;
          o.reaped_valid = 1'b1;
          o.reaped_slot = s[3:0];
        end else begin
          o.status = put_to_sleep(init_id);
        end
      end
      default: ;
    endcase
    o.running_slot = running[4:0];
    o.running_pid = (running < SLOTS) ? pid_of[running] : '0;
    o.switched = (running != prev);
    return o;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    outcome_t exp_o;
    if (rst) begin
      foreach (state_of[i]) begin
        state_of[i] = ST_UNUSED;
        pid_of[i] = '0;
        event_of[i] = '0;
      end
      ready_q.delete();
      sleepers.delete();
      killed_q.delete();
      expected_q.delete();
      running = SLOTS;
      pid_next = 1;
      init_id = 16'd1;
      fail_count = 0;
    end else begin
      if (cfg_we) init_id = cfg_data;
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          $error("response with no request outstanding");
          fail_count++;
        end else begin
          exp_o = expected_q.pop_front();
          compare_field("status", exp_o.status, rsp.status);
          compare_field("running_slot", exp_o.running_slot, rsp.running_slot);
          compare_field("running_pid", exp_o.running_pid, rsp.running_pid);
          compare_field("switched", exp_o.switched, rsp.switched);
          compare_field("created_slot", exp_o.created_slot, rsp.created_slot);
          compare_field("created_pid", exp_o.created_pid, rsp.created_pid);
          compare_field("woken_count", exp_o.woken_count, rsp.woken_count);
          compare_field("reaped_valid", exp_o.reaped_valid, rsp.reaped_valid);
          compare_field("reaped_slot", exp_o.reaped_slot, rsp.reaped_slot);
        end
      end
      if (req.valid && req.ready)
        expected_q.push_back(schedule(mode_t'(req.mode), req.wait_id));
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the task state scheduler testbench: clock, reset, request stimulus,
// config writes and verdict. Depends on tss_pkg, tss_if, tss_checker, the RTL.
module testbench;
  import tss_pkg::*;

  localparam int SLOTS = 16;
  localparam int STALL_LIMIT = 4000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;
  int          sender_idle;
  int          receiver_idle;
  int          idle_cycles;
  int          sent;
  int          wake_ids_seen;
  bit          timed_out;
  logic [15:0] cur_init;

  tss_req_if req ();
  tss_rsp_if rsp ();

  task_state_scheduler #(.SLOTS(SLOTS)) u_top (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  tss_checker #(.SLOTS(SLOTS)) u_checker (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(99) >= receiver_idle);
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles > STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send(mode_t m, logic [15:0] wid);
    while ($urandom_range(99) < sender_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.mode <= m;
    req.wait_id <= wid;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
  endtask

  task automatic write_init(logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    cur_init = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // pick a wait id: mostly from a small pool so wakeups find sleepers
  function automatic logic [15:0] pick_id();
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return cur_init;
      default: return {1'($urandom_range(1)), 13'd0, 2'($urandom_range(3))};
    endcase
  endfunction

  task automatic random_phase(int n);
    int r;
    mode_t m;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 18) m = MODE_CREATE;
      else if (r < 26) m = MODE_START;
      else if (r < 40) m = MODE_YIELD;
      else if (r < 55) m = MODE_SLEEP;
      else if (r < 70) m = MODE_WAKEUP;
      else if (r < 82) m = MODE_EXIT;
      else if (r < 97) m = MODE_REAP;
      else m = MODE_NONE;
      if (m == MODE_WAKEUP) wake_ids_seen++;
      send(m, pick_id());
    end
  endtask

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.mode = MODE_CREATE;
    req.wait_id = '0;
    rsp.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    idle_cycles = 0;
    sent = 0;
    wake_ids_seen = 0;
    timed_out = 1'b0;
    cur_init = 16'd1;
    sender_idle = 26;
    receiver_idle = 54;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // rejections and no-op requests on an empty scheduler
    send(MODE_START, 16'd0);
    send(MODE_YIELD, 16'd0);
    send(MODE_SLEEP, 16'hFFFF);
    send(MODE_EXIT, 16'd0);
    send(MODE_REAP, 16'd0);
    send(MODE_WAKEUP, 16'hFFFF);
    send(MODE_NONE, 16'hFFFF);
    // fill every slot, then overflow
    for (int i = 0; i < SLOTS + 1; i++) send(MODE_CREATE, 16'd0);
    send(MODE_START, 16'd0);
    send(MODE_START, 16'd0);
    send(MODE_YIELD, 16'd0);
    send(MODE_SLEEP, 16'hFFFF);
    send(MODE_WAKEUP, 16'hFFFF);
    send(MODE_EXIT, 16'd0);
    send(MODE_REAP, 16'd0);
    send(MODE_REAP, 16'd0);

    random_phase(180);
    write_init(16'hFFFF);
    random_phase(90);
    sender_idle = 54;
    receiver_idle = 26;
    write_init(16'd0);
    random_phase(90);
    sender_idle = 0;
    receiver_idle = 0;
    write_init(16'h8002);
    random_phase(90);
    write_init(16'd1);
    random_phase(70);
    drain();

    $display("Ran %0d requests (%0d wakeups) across 5 init wait id settings", sent,
             wake_ids_seen);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
